// ===== rtl/dtq_pkg.sv =====
// Shared types, codes and constants of the deadline trigger queue.
package dtq_pkg;

	// Default queue depth and per-item fire limit
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_RESULTS     = 16;

	// Field widths
	localparam int ID_W    = 8;
	localparam int TIME_W  = 64;
	localparam int CMD_W   = 2;
	localparam int STAT_W  = 3;
	localparam int FCNT_W  = 5;
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 80;

	// Input commands
	localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH    = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_FIRED_DUE    = 3'd0;
	localparam logic [STAT_W-1:0] ST_FIRED_INSERT = 3'd1;
	localparam logic [STAT_W-1:0] ST_QUEUED       = 3'd2;
	localparam logic [STAT_W-1:0] ST_REJECTED     = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOTHING      = 3'd4;

	// Source of an emitted result
	localparam logic [1:0] EK_INPUT = 2'd0;
	localparam logic [1:0] EK_HELD  = 2'd1;
	localparam logic [1:0] EK_NONE  = 2'd2;

	// One queue entry
	typedef struct packed {
		logic [TIME_W-1:0] deadline;
		logic [ID_W-1:0]   id;
	} entry_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic              load_item;
		logic              j_load;
		logic              j_dec;
		logic              rd_en;
		logic              rd_head;
		logic              wr_en;
		logic              wr_new;
		logic              push;
		logic              pop;
		logic              emit;
		logic [1:0]        emit_kind;
		logic [STAT_W-1:0] emit_status;
		logic              emit_last;
	} ctl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             fire_now;
		logic             full;
		logic             count_zero;
		logic             j_zero;
		logic             rdata_gt;
		logic             due;
		logic             k_max;
		logic             out_free;
	} sts_t;

endpackage

// ===== rtl/deadline_trigger_queue.sv =====
// Result path: an immediate fire or a reject is emitted straight from the decide state; a queued
// insert walks from the tail toward the head, one RAM read and one compare per later-deadline
// entry shifted past, and writes the new entry where it stops; a tick or flush pops due entries
// from the head, emitting each, or emits a lone "nothing due". Backpressure stalls all of these.
// Items are taken one at a time: a new one is accepted only after the serial RAM walk of the last.
// Reset: arst_n clears state, counters, time and result valid at once; the store is not cleared.
module deadline_trigger_queue #(
	parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dtq_pkg::S_DATA_W-1:0]    s_tdata,  // trigger_id[7:0], time_value[71:8]
	input  logic [dtq_pkg::CMD_W-1:0]       s_tuser,  // command[1:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dtq_pkg::M_DATA_W-1:0]    m_tdata,  // fired_id[7:0], fired_deadline[71:8],
	                                                  // fire_count[76:72], zero[79:77]
	output logic [dtq_pkg::STAT_W-1:0]      m_tuser,  // status[2:0]
	output logic                            m_tlast
);

	dtq_pkg::ctl_t ctl;
	dtq_pkg::sts_t sts;

	logic [dtq_pkg::ID_W-1:0]   out_id;
	logic [dtq_pkg::TIME_W-1:0] out_deadline;
	logic [dtq_pkg::FCNT_W-1:0] out_count;

	dtq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.sts     (sts),
		.ctl     (ctl)
	);

	dtq_dpath #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_cmd      (s_tuser),
		.in_id       (s_tdata[7:0]),
		.in_time     (s_tdata[71:8]),
		.ctl         (ctl),
		.sts         (sts),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_id      (out_id),
		.out_deadline(out_deadline),
		.out_status  (m_tuser),
		.out_count   (out_count),
		.out_last    (m_tlast)
	);

	// Pack the result transaction
	assign m_tdata = {3'b000, out_count, out_deadline, out_id};

endmodule

// ===== rtl/dtq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/dtq_ctrl.sv =====
// Controller state machine of the deadline trigger queue.
module dtq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  dtq_pkg::sts_t sts,
	output dtq_pkg::ctl_t ctl
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECIDE   = 4'd1;
	localparam logic [3:0] S_INS_RD   = 4'd2;
	localparam logic [3:0] S_INS_CMP  = 4'd3;
	localparam logic [3:0] S_INS_DONE = 4'd4;
	localparam logic [3:0] S_DR_RD0   = 4'd5;
	localparam logic [3:0] S_DR_CMP0  = 4'd6;
	localparam logic [3:0] S_DR_RD    = 4'd7;
	localparam logic [3:0] S_DR_CMP   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d         = state_q;
		ctl             = '0;
		ctl.emit_kind   = dtq_pkg::EK_NONE;
		ctl.emit_status = dtq_pkg::ST_NOTHING;
		ctl.emit_last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load_item = 1'b1;
					state_d       = S_DECIDE;
				end
			end
			S_DECIDE: begin
				case (sts.cmd)
					dtq_pkg::CMD_REGISTER: begin
						if (sts.fire_now || sts.full) begin
							ctl.emit_kind   = dtq_pkg::EK_INPUT;
							ctl.emit_status = sts.fire_now ? dtq_pkg::ST_FIRED_INSERT
							                               : dtq_pkg::ST_REJECTED;
							if (sts.out_free) begin
								ctl.emit = 1'b1;
								state_d  = S_IDLE;
							end
						end else begin
							ctl.j_load = 1'b1;
							state_d    = S_INS_RD;
						end
					end
					dtq_pkg::CMD_TICK, dtq_pkg::CMD_FLUSH: begin
						state_d = S_DR_RD0;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_INS_RD: begin
				if (sts.j_zero) begin
					ctl.wr_en  = 1'b1;
					ctl.wr_new = 1'b1;
					ctl.push   = 1'b1;
					state_d    = S_INS_DONE;
				end else begin
					ctl.rd_en = 1'b1;
					state_d   = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				ctl.wr_en = 1'b1;
				if (sts.rdata_gt) begin
					ctl.j_dec = 1'b1;
					state_d   = S_INS_RD;
				end else begin
					ctl.wr_new = 1'b1;
					ctl.push   = 1'b1;
					state_d    = S_INS_DONE;
				end
			end
			S_INS_DONE: begin
				ctl.emit_kind   = dtq_pkg::EK_INPUT;
				ctl.emit_status = dtq_pkg::ST_QUEUED;
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_DR_RD0: begin
				if (sts.count_zero) begin
					if (sts.out_free) begin
						ctl.emit = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					ctl.rd_en   = 1'b1;
					ctl.rd_head = 1'b1;
					state_d     = S_DR_CMP0;
				end
			end
			S_DR_CMP0: begin
				if (sts.due) begin
					ctl.pop = 1'b1;
					state_d = S_DR_RD;
				end else if (sts.out_free) begin
					ctl.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_DR_RD: begin
				ctl.emit_kind   = dtq_pkg::EK_HELD;
				ctl.emit_status = dtq_pkg::ST_FIRED_DUE;
				if (sts.count_zero || sts.k_max) begin
					if (sts.out_free) begin
						ctl.emit = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					ctl.rd_en   = 1'b1;
					ctl.rd_head = 1'b1;
					state_d     = S_DR_CMP;
				end
			end
			S_DR_CMP: begin
				ctl.emit_kind   = dtq_pkg::EK_HELD;
				ctl.emit_status = dtq_pkg::ST_FIRED_DUE;
				ctl.emit_last   = !sts.due;
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					if (sts.due) begin
						ctl.pop = 1'b1;
						state_d = S_DR_RD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/dtq_dpath.sv =====
// Datapath of the deadline trigger queue: circular sorted store, counters, result register.
module dtq_dpath #(
	parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [dtq_pkg::CMD_W-1:0]       in_cmd,
	input  logic [dtq_pkg::ID_W-1:0]        in_id,
	input  logic [dtq_pkg::TIME_W-1:0]      in_time,
	input  dtq_pkg::ctl_t                   ctl,
	output dtq_pkg::sts_t                   sts,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [dtq_pkg::ID_W-1:0]        out_id,
	output logic [dtq_pkg::TIME_W-1:0]      out_deadline,
	output logic [dtq_pkg::STAT_W-1:0]      out_status,
	output logic [dtq_pkg::FCNT_W-1:0]      out_count,
	output logic                            out_last
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = AW + 1;
	localparam int EW = $bits(dtq_pkg::entry_t);

	logic [dtq_pkg::CMD_W-1:0]  cmd_q;
	logic [dtq_pkg::ID_W-1:0]   id_q;
	logic [dtq_pkg::TIME_W-1:0] tv_q;
	logic [dtq_pkg::TIME_W-1:0] cur_time_q;
	logic [AW-1:0]              head_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              j_q;
	logic [dtq_pkg::FCNT_W-1:0] k_q;
	dtq_pkg::entry_t            held_q;
	logic                       out_valid_q;

	dtq_pkg::entry_t rdata;
	dtq_pkg::entry_t new_entry;
	dtq_pkg::entry_t wdata;
	logic [AW-1:0]   waddr;
	logic [AW-1:0]   raddr;
	logic [AW-1:0]   ins_raddr;
	logic [EW-1:0]   rdata_raw;
	logic            out_free;

	// Offset from head, wrapped into the store
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
	                                           input logic [CW-1:0] offs);
		logic [SW-1:0] sum;
		sum = {1'b0, base} + SW'(offs);
		if (sum >= SW'(QUEUE_DEPTH)) begin
			sum = sum - SW'(QUEUE_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign new_entry.deadline = tv_q;
	assign new_entry.id       = id_q;
	assign rdata              = dtq_pkg::entry_t'(rdata_raw);
	assign wdata              = ctl.wr_new ? new_entry : rdata;
	assign waddr              = wrap_add(head_q, j_q);
	assign ins_raddr          = wrap_add(head_q, j_q - CW'(1));
	assign raddr              = ctl.rd_head ? head_q : ins_raddr;
	assign out_free           = !out_valid_q || out_ready;

	dtq_ram #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ctl.wr_en),
		.waddr(waddr),
		.wdata(wdata),
		.re   (ctl.rd_en),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	// Status toward the controller
	assign sts.cmd        = cmd_q;
	assign sts.fire_now   = (cur_time_q >= tv_q);
	assign sts.full       = (count_q >= CW'(QUEUE_DEPTH));
	assign sts.count_zero = (count_q == '0);
	assign sts.j_zero     = (j_q == '0);
	assign sts.rdata_gt   = (rdata.deadline > tv_q);
	assign sts.due        = (cmd_q == dtq_pkg::CMD_FLUSH) || (rdata.deadline <= tv_q);
	assign sts.k_max      = (k_q == dtq_pkg::FCNT_W'(dtq_pkg::MAX_RESULTS));
	assign sts.out_free   = out_free;

	// Latch the accepted transaction
	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			cmd_q <= in_cmd;
			id_q  <= in_id;
			tv_q  <= in_time;
		end
	end

	// Hold the entry waiting for its last flag
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			held_q <= rdata;
		end
	end

	// Time, queue pointers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_time_q <= '0;
			head_q     <= '0;
			count_q    <= '0;
			j_q        <= '0;
			k_q        <= '0;
		end else begin
			if (ctl.load_item) begin
				k_q <= '0;
				if (in_cmd == dtq_pkg::CMD_TICK) begin
					cur_time_q <= in_time;
				end
			end
			if (ctl.j_load) begin
				j_q <= count_q;
			end else if (ctl.j_dec) begin
				j_q <= j_q - CW'(1);
			end
			if (ctl.push) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.pop) begin
				count_q <= count_q - CW'(1);
				head_q  <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
				k_q     <= k_q + dtq_pkg::FCNT_W'(1);
			end
		end
	end

	// Result register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_status <= ctl.emit_status;
			out_last   <= ctl.emit_last;
			case (ctl.emit_kind)
				dtq_pkg::EK_INPUT: begin
					out_id       <= id_q;
					out_deadline <= tv_q;
					out_count    <= (ctl.emit_status == dtq_pkg::ST_FIRED_INSERT)
					                ? dtq_pkg::FCNT_W'(1) : '0;
				end
				dtq_pkg::EK_HELD: begin
					out_id       <= held_q.id;
					out_deadline <= held_q.deadline;
					out_count    <= k_q;
				end
				default: begin
					out_id       <= '0;
					out_deadline <= '0;
					out_count    <= '0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// Queue never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("pending count above queue depth");

	// An item fires no more than the result limit
	a_fire_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= dtq_pkg::FCNT_W'(dtq_pkg::MAX_RESULTS))
		else $error("fire count above limit");

	// Pop only from a non-empty queue, push only into a non-full one
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> count_q != '0)
		else $error("pop from empty queue");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> count_q < CW'(QUEUE_DEPTH))
		else $error("push into full queue");

	// A result is loaded only when the register is free
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> out_free)
		else $error("result register overwritten");

endmodule
